/* rtl/argr_pkg.sv */
// Shared constants, opcodes and the emitter request type for the adaptive
// rank Golomb-Rice codec. No dependencies.
package argr_pkg;

  localparam int SYM_W              = 8;
  localparam int ADDR_W             = 16;
  localparam int WORD_BITS          = 32;
  localparam int FILL_W             = 5;
  localparam int FREQ_WIDTH_DEF     = 16;
  localparam int ADAPT_PERIOD_DEF   = 256;
  localparam int RUN_W              = 9;

  localparam logic [1:0] OP_DATA   = 2'd0;
  localparam logic [1:0] OP_FINISH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [8:0]  END_CODE = 9'd256;
  localparam logic [8:0]  RUN_MAX  = 9'd511;
  localparam logic [2:0]  K_RESET  = 3'd3;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic                   push;
    logic                   fin;
    logic                   fin_end;
    logic                   end_flag;
    logic [WORD_BITS-1:0]   value;
  } emit_req_t;

endpackage

/* rtl/argr_tables.sv */
// Context tables of the codec: frequency counts, rank-to-symbol and
// symbol-to-rank, one port each with registered read. Uses argr_pkg.
module argr_tables import argr_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic [ADDR_W-1:0]     freq_addr,
  input  logic                  freq_we,
  input  logic [FREQ_WIDTH-1:0] freq_wd,
  output logic [FREQ_WIDTH-1:0] freq_rd,
  input  logic [ADDR_W-1:0]     r2s_addr,
  input  logic                  r2s_we,
  input  logic [SYM_W-1:0]      r2s_wd,
  output logic [SYM_W-1:0]      r2s_rd,
  input  logic [ADDR_W-1:0]     s2r_addr,
  input  logic                  s2r_we,
  input  logic [SYM_W-1:0]      s2r_wd,
  output logic [SYM_W-1:0]      s2r_rd
);

  logic [FREQ_WIDTH-1:0] freq_mem [2**ADDR_W];
  logic [SYM_W-1:0]      r2s_mem  [2**ADDR_W];
  logic [SYM_W-1:0]      s2r_mem  [2**ADDR_W];

  // Write or read each table at its own address
  always_ff @(posedge clk) begin
    if (freq_we) begin
      freq_mem[freq_addr] <= freq_wd;
    end
    freq_rd <= freq_mem[freq_addr];
  end

  always_ff @(posedge clk) begin
    if (r2s_we) begin
      r2s_mem[r2s_addr] <= r2s_wd;
    end
    r2s_rd <= r2s_mem[r2s_addr];
  end

  always_ff @(posedge clk) begin
    if (s2r_we) begin
      s2r_mem[s2r_addr] <= s2r_wd;
    end
    s2r_rd <= s2r_mem[s2r_addr];
  end

endmodule

/* rtl/argr_emit.sv */
// Output stage: holds one pending result until the next one or the end of
// the item says whether it is the last, plus the output register. Uses argr_pkg.
module argr_emit import argr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  emit_req_t            req,
  output logic                 rdy,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_BITS-1:0] out_tdata,   // value
  output logic                 out_tuser,   // stream_end
  output logic                 out_tlast    // last
);

  logic                 pend_v_r, pend_v_nxt;
  logic [WORD_BITS-1:0] pend_val_r, pend_val_nxt;
  logic                 pend_end_r, pend_end_nxt;
  logic                 out_v_r, out_v_nxt;
  logic [WORD_BITS-1:0] out_val_r, out_val_nxt;
  logic                 out_end_r, out_end_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_free;

  assign out_free = !out_v_r || out_tready;
  assign rdy      = !pend_v_r || out_free;

  // Move the pending result out on a new push or on the end of the item
  always_comb begin
    pend_v_nxt   = pend_v_r;
    pend_val_nxt = pend_val_r;
    pend_end_nxt = pend_end_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_val_nxt  = out_val_r;
    out_end_nxt  = out_end_r;
    out_last_nxt = out_last_r;
    if (req.push && rdy) begin
      if (pend_v_r) begin
        out_v_nxt    = 1'b1;
        out_val_nxt  = pend_val_r;
        out_end_nxt  = pend_end_r;
        out_last_nxt = 1'b0;
      end
      pend_v_nxt   = 1'b1;
      pend_val_nxt = req.value;
      pend_end_nxt = req.end_flag;
    end else if (req.fin && rdy && pend_v_r) begin
      out_v_nxt    = 1'b1;
      out_val_nxt  = pend_val_r;
      out_end_nxt  = pend_end_r | req.fin_end;
      out_last_nxt = 1'b1;
      pend_v_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
    pend_val_r <= pend_val_nxt;
    pend_end_r <= pend_end_nxt;
    out_val_r  <= out_val_nxt;
    out_end_r  <= out_end_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_end_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/adaptive_rank_golomb_rice_codec_core.sv */
// Top level of the adaptive rank Golomb-Rice byte codec: sequencer, coder
// state and rank update. Uses argr_pkg, argr_tables and argr_emit.
//
//  channel | ports                               | contents
//  in      | in_tvalid/in_tready/in_tdata/tuser  | tdata: data[31:0]; tuser: opcode[1:0]
//  out     | out_tvalid/out_tready/out_tdata/... | tdata: value; tuser: stream_end; tlast: last
//  cfg     | cfg_we/cfg_wdata                    | direction
//
// One item at a time; in_tready is high only between items. Compressing a
// byte reads its rank, then emits (rank >> k) zeros, a one and the k low
// rank bits (one bit a cycle while the output stage takes each full word),
// reads and bumps the count, steps the rank ahead while the symbol above
// has a lower count (no compare once it reaches rank 0), swaps and closes.
// Decompressing walks the word one bit a cycle; each symbol adds a lookup
// and a result, the same update and a resume step. After reset and after a
// clear a pass over all 65536 entries rewrites the tables. A stalled output
// holds the sequencer only when a result is already pending.
module adaptive_rank_golomb_rice_codec_core import argr_pkg::*; #(
  parameter int FREQ_WIDTH   = FREQ_WIDTH_DEF,
  parameter int ADAPT_PERIOD = ADAPT_PERIOD_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [WORD_BITS-1:0] in_tdata,    // data
  input  logic [1:0]           in_tuser,    // opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [WORD_BITS-1:0] out_tdata,   // value
  output logic                 out_tuser,   // stream_end
  output logic                 out_tlast,   // last
  input  logic                 cfg_we,
  input  logic                 cfg_wdata
);

  localparam int SUM_W = $clog2(ADAPT_PERIOD * 255 + 1);
  localparam int CNT_W = $clog2(ADAPT_PERIOD + 1);

  localparam logic [4:0] S_CLR    = 5'd0;
  localparam logic [4:0] S_IDLE   = 5'd1;
  localparam logic [4:0] S_E_RD   = 5'd2;
  localparam logic [4:0] S_E_RK   = 5'd3;
  localparam logic [4:0] S_E_Z    = 5'd4;
  localparam logic [4:0] S_E_K    = 5'd5;
  localparam logic [4:0] S_E_FL   = 5'd6;
  localparam logic [4:0] S_FIN    = 5'd7;
  localparam logic [4:0] S_L_F    = 5'd8;
  localparam logic [4:0] S_L_W    = 5'd9;
  localparam logic [4:0] S_L_R    = 5'd10;
  localparam logic [4:0] S_L_Q    = 5'd11;
  localparam logic [4:0] S_L_C    = 5'd12;
  localparam logic [4:0] S_L_SW   = 5'd13;
  localparam logic [4:0] S_L_SW2  = 5'd14;
  localparam logic [4:0] S_D_NX   = 5'd15;
  localparam logic [4:0] S_D_BIT  = 5'd16;
  localparam logic [4:0] S_D_RD   = 5'd17;
  localparam logic [4:0] S_D_SYM  = 5'd18;
  localparam logic [4:0] S_D_END  = 5'd19;

  logic [4:0]            st_r, st_nxt;
  logic [1:0]            op_r, op_nxt;
  logic [WORD_BITS-1:0]  word_r, word_nxt;
  logic                  dir_r;
  logic [SYM_W-1:0]      prev_r, prev_nxt;
  logic [2:0]            k_r, k_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [WORD_BITS-1:0]  buf_r, buf_nxt;
  logic [FILL_W-1:0]     fill_r, fill_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic                  ph_r, ph_nxt;
  logic [SYM_W-1:0]      rem_r, rem_nxt;
  logic [2:0]            tk_r, tk_nxt;
  logic [8:0]            code_r, code_nxt;
  logic [8:0]            zq_r, zq_nxt;
  logic [2:0]            kx_r, kx_nxt;
  logic [FILL_W-1:0]     bi_r, bi_nxt;
  logic [SYM_W-1:0]      sym_r, sym_nxt;
  logic [SYM_W-1:0]      j_r, j_nxt;
  logic [SYM_W-1:0]      d_r, d_nxt;
  logic [SYM_W-1:0]      cand_r, cand_nxt;
  logic [FREQ_WIDTH-1:0] f_r, f_nxt;
  logic                  ret_dec_r, ret_dec_nxt;
  logic                  finend_r, finend_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;

  logic [ADDR_W-1:0]     freq_addr, r2s_addr, s2r_addr;
  logic                  freq_we, r2s_we, s2r_we;
  logic [FREQ_WIDTH-1:0] freq_wd, freq_rd;
  logic [SYM_W-1:0]      r2s_wd, r2s_rd, s2r_wd, s2r_rd;

  emit_req_t             em_req;
  logic                  em_rdy;

  logic                  bit_v;
  logic                  code_done;
  logic [2:0]            k_calc;
  logic [SYM_W-1:0]      rem_n;
  logic [2:0]            tk_n;
  logic [15:0]           dec_v;
  logic                  sym_done;

  argr_tables #(.FREQ_WIDTH(FREQ_WIDTH)) u_tables (
    .clk       (clk),
    .freq_addr (freq_addr),
    .freq_we   (freq_we),
    .freq_wd   (freq_wd),
    .freq_rd   (freq_rd),
    .r2s_addr  (r2s_addr),
    .r2s_we    (r2s_we),
    .r2s_wd    (r2s_wd),
    .r2s_rd    (r2s_rd),
    .s2r_addr  (s2r_addr),
    .s2r_we    (s2r_we),
    .s2r_wd    (s2r_wd),
    .s2r_rd    (s2r_rd)
  );

  argr_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (em_req),
    .rdy        (em_rdy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  assign in_tready = (st_r == S_IDLE);

  // New k from the rank mean: largest k with interval << k <= sum
  always_comb begin
    k_calc = 3'd0;
    for (int t = 1; t < 8; t++) begin
      if ((32'(ADAPT_PERIOD) << t) <= 32'(sum_r)) begin
        k_calc = 3'(t);
      end
    end
  end

  // Table addresses and writes for each step
  always_comb begin
    freq_addr = {prev_r, sym_r};
    r2s_addr  = {prev_r, code_r[SYM_W-1:0]};
    s2r_addr  = {prev_r, word_r[SYM_W-1:0]};
    freq_we   = 1'b0;
    r2s_we    = 1'b0;
    s2r_we    = 1'b0;
    freq_wd   = f_nxt;
    r2s_wd    = sym_r;
    s2r_wd    = j_r;
    unique case (st_r)
      S_CLR: begin
        freq_addr = clr_r;
        r2s_addr  = clr_r;
        s2r_addr  = clr_r;
        freq_we   = 1'b1;
        r2s_we    = 1'b1;
        s2r_we    = 1'b1;
        freq_wd   = '0;
        r2s_wd    = clr_r[SYM_W-1:0];
        s2r_wd    = clr_r[SYM_W-1:0];
      end
      S_L_W: begin
        freq_we = 1'b1;
      end
      S_L_R: begin
        r2s_addr = {prev_r, 8'(j_r - 8'd1)};
      end
      S_L_Q: begin
        freq_addr = {prev_r, r2s_rd};
      end
      S_L_SW: begin
        r2s_addr = {prev_r, j_r};
        s2r_addr = {prev_r, sym_r};
        r2s_we   = (j_r != code_r[SYM_W-1:0]);
        s2r_we   = (j_r != code_r[SYM_W-1:0]);
      end
      S_L_SW2: begin
        r2s_addr = {prev_r, code_r[SYM_W-1:0]};
        s2r_addr = {prev_r, d_r};
        r2s_we   = 1'b1;
        s2r_we   = 1'b1;
        r2s_wd   = d_r;
        s2r_wd   = code_r[SYM_W-1:0];
      end
      default: begin
      end
    endcase
  end

  // Decoder bit step: remainder bit insert and code value
  always_comb begin
    rem_n = rem_r | (8'(word_r[bi_r]) << tk_r);
    tk_n  = tk_r + 3'd1;
    if (ph_r) begin
      dec_v = (16'(run_r) << k_r) | 16'(rem_n);
    end else begin
      dec_v = 16'(run_r) << k_r;
    end
  end

  // Sequencer
  always_comb begin
    st_nxt      = st_r;
    op_nxt      = op_r;
    word_nxt    = word_r;
    prev_nxt    = prev_r;
    k_nxt       = k_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    buf_nxt     = buf_r;
    fill_nxt    = fill_r;
    run_nxt     = run_r;
    ph_nxt      = ph_r;
    rem_nxt     = rem_r;
    tk_nxt      = tk_r;
    code_nxt    = code_r;
    zq_nxt      = zq_r;
    kx_nxt      = kx_r;
    bi_nxt      = bi_r;
    sym_nxt     = sym_r;
    j_nxt       = j_r;
    d_nxt       = d_r;
    cand_nxt    = cand_r;
    f_nxt       = f_r;
    ret_dec_nxt = ret_dec_r;
    finend_nxt  = finend_r;
    clr_nxt     = clr_r;
    em_req      = '0;
    bit_v       = 1'b0;
    code_done   = 1'b0;
    sym_done    = 1'b0;

    unique case (st_r)
      S_CLR: begin
        clr_nxt = clr_r + 16'd1;
        if (clr_r == '1) begin
          st_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = in_tuser;
          word_nxt = in_tdata;
          case (in_tuser)
            OP_CLEAR: begin
              st_nxt   = S_CLR;
              clr_nxt  = '0;
              prev_nxt = '0;
              k_nxt    = K_RESET;
              sum_nxt  = '0;
              cnt_nxt  = '0;
              buf_nxt  = '0;
              fill_nxt = '0;
              run_nxt  = '0;
              ph_nxt   = 1'b0;
              rem_nxt  = '0;
              tk_nxt   = '0;
            end
            OP_DATA: begin
              bi_nxt = '0;
              st_nxt = dir_r ? S_D_BIT : S_E_RD;
            end
            OP_FINISH: begin
              if (dir_r) begin
                run_nxt  = '0;
                ph_nxt   = 1'b0;
                rem_nxt  = '0;
                tk_nxt   = '0;
                prev_nxt = '0;
              end else begin
                code_nxt = END_CODE;
                zq_nxt   = END_CODE >> k_r;
                kx_nxt   = '0;
                st_nxt   = S_E_Z;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_E_RD: begin
        st_nxt = S_E_RK;
      end

      S_E_RK: begin
        code_nxt = {1'b0, s2r_rd};
        zq_nxt   = {1'b0, s2r_rd} >> k_r;
        kx_nxt   = '0;
        st_nxt   = S_E_Z;
      end

      // Emit one code bit a cycle, holding while a full word waits for the output stage
      S_E_Z, S_E_K: begin
        if (st_r == S_E_Z) begin
          bit_v = (zq_r == '0);
        end else begin
          bit_v = code_r[kx_r];
        end
        em_req.value    = buf_r | (32'(bit_v) << (WORD_BITS - 1));
        em_req.end_flag = 1'b0;
        if (fill_r == '1) begin
          em_req.push = 1'b1;
        end
        if (fill_r != '1 || em_rdy) begin
          if (fill_r == '1) begin
            buf_nxt  = '0;
            fill_nxt = '0;
          end else begin
            buf_nxt  = buf_r | (32'(bit_v) << fill_r);
            fill_nxt = fill_r + 5'd1;
          end
          if (st_r == S_E_Z) begin
            if (zq_r != '0) begin
              zq_nxt = zq_r - 9'd1;
            end else if (k_r == '0) begin
              code_done = 1'b1;
            end else begin
              st_nxt = S_E_K;
            end
          end else begin
            if (kx_r == 3'(k_r - 3'd1)) begin
              code_done = 1'b1;
            end else begin
              kx_nxt = kx_r + 3'd1;
            end
          end
          if (code_done) begin
            if (op_r == OP_DATA) begin
              sym_nxt     = word_r[SYM_W-1:0];
              ret_dec_nxt = 1'b0;
              st_nxt      = S_L_F;
            end else begin
              st_nxt = S_E_FL;
            end
          end
        end
      end

      // Flush the partial word at the end of a stream
      S_E_FL: begin
        em_req.value    = buf_r;
        em_req.end_flag = 1'b0;
        em_req.push     = (fill_r != '0);
        if (fill_r == '0 || em_rdy) begin
          buf_nxt    = '0;
          fill_nxt   = '0;
          prev_nxt   = '0;
          finend_nxt = 1'b1;
          st_nxt     = S_FIN;
        end
      end

      S_FIN: begin
        em_req.fin     = 1'b1;
        em_req.fin_end = finend_r;
        if (em_rdy) begin
          st_nxt = S_IDLE;
        end
      end

      // Count update: read, bump with saturation, write back
      S_L_F: begin
        st_nxt = S_L_W;
      end

      S_L_W: begin
        f_nxt = (freq_rd == '1) ? freq_rd : freq_rd + 1'b1;
        j_nxt = code_r[SYM_W-1:0];
        st_nxt = (code_r[SYM_W-1:0] == '0) ? S_L_SW : S_L_R;
      end

      // Rank walk: step ahead while the symbol above has a lower count
      S_L_R: begin
        st_nxt = S_L_Q;
      end

      S_L_Q: begin
        cand_nxt = r2s_rd;
        st_nxt   = S_L_C;
      end

      S_L_C: begin
        if (freq_rd < f_r) begin
          j_nxt  = j_r - 8'd1;
          d_nxt  = cand_r;
          st_nxt = (j_r == 8'd1) ? S_L_SW : S_L_R;
        end else begin
          st_nxt = S_L_SW;
        end
      end

      // First half of the swap, plus the k adaptation
      S_L_SW: begin
        if (cnt_r == CNT_W'(ADAPT_PERIOD)) begin
          k_nxt   = k_calc;
          sum_nxt = SUM_W'(code_r[SYM_W-1:0]);
          cnt_nxt = CNT_W'(1);
        end else begin
          sum_nxt = sum_r + SUM_W'(code_r[SYM_W-1:0]);
          cnt_nxt = cnt_r + CNT_W'(1);
        end
        if (j_r == code_r[SYM_W-1:0]) begin
          prev_nxt = sym_r;
          if (ret_dec_r) begin
            st_nxt = S_D_NX;
          end else begin
            finend_nxt = 1'b0;
            st_nxt     = S_FIN;
          end
        end else begin
          st_nxt = S_L_SW2;
        end
      end

      S_L_SW2: begin
        prev_nxt = sym_r;
        if (ret_dec_r) begin
          st_nxt = S_D_NX;
        end else begin
          finend_nxt = 1'b0;
          st_nxt     = S_FIN;
        end
      end

      S_D_NX: begin
        if (bi_r == '1) begin
          finend_nxt = 1'b0;
          st_nxt     = S_FIN;
        end else begin
          bi_nxt = bi_r + 5'd1;
          st_nxt = S_D_BIT;
        end
      end

      // Decode one bit of the held word
      S_D_BIT: begin
        if (!ph_r) begin
          if (!word_r[bi_r]) begin
            if (run_r != RUN_MAX) begin
              run_nxt = run_r + 9'd1;
            end
          end else if (k_r != '0) begin
            rem_nxt = '0;
            tk_nxt  = '0;
            ph_nxt  = 1'b1;
          end else begin
            sym_done = 1'b1;
          end
        end else begin
          if (tk_n < k_r) begin
            rem_nxt = rem_n;
            tk_nxt  = tk_n;
          end else begin
            sym_done = 1'b1;
          end
        end
        if (sym_done) begin
          run_nxt = '0;
          ph_nxt  = 1'b0;
          rem_nxt = '0;
          tk_nxt  = '0;
          if (dec_v >= 16'(END_CODE)) begin
            st_nxt = S_D_END;
          end else begin
            code_nxt = 9'(dec_v);
            st_nxt   = S_D_RD;
          end
        end else if (bi_r == '1) begin
          finend_nxt = 1'b0;
          st_nxt     = S_FIN;
        end else begin
          bi_nxt = bi_r + 5'd1;
        end
      end

      S_D_RD: begin
        st_nxt = S_D_SYM;
      end

      S_D_SYM: begin
        em_req.push     = 1'b1;
        em_req.value    = 32'(r2s_rd);
        em_req.end_flag = 1'b0;
        if (em_rdy) begin
          sym_nxt     = r2s_rd;
          ret_dec_nxt = 1'b1;
          st_nxt      = S_L_F;
        end
      end

      // End code: report it and drop the rest of the word
      S_D_END: begin
        em_req.push     = 1'b1;
        em_req.value    = '0;
        em_req.end_flag = 1'b1;
        if (em_rdy) begin
          prev_nxt   = '0;
          finend_nxt = 1'b0;
          st_nxt     = S_FIN;
        end
      end

      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  // Hold the direction register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r <= 1'b0;
    end else if (cfg_we) begin
      dir_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= S_CLR;
      clr_r     <= '0;
      prev_r    <= '0;
      k_r       <= K_RESET;
      sum_r     <= '0;
      cnt_r     <= '0;
      buf_r     <= '0;
      fill_r    <= '0;
      run_r     <= '0;
      ph_r      <= 1'b0;
      rem_r     <= '0;
      tk_r      <= '0;
      ret_dec_r <= 1'b0;
      finend_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      clr_r     <= clr_nxt;
      prev_r    <= prev_nxt;
      k_r       <= k_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      buf_r     <= buf_nxt;
      fill_r    <= fill_nxt;
      run_r     <= run_nxt;
      ph_r      <= ph_nxt;
      rem_r     <= rem_nxt;
      tk_r      <= tk_nxt;
      ret_dec_r <= ret_dec_nxt;
      finend_r  <= finend_nxt;
    end
    op_r   <= op_nxt;
    word_r <= word_nxt;
    code_r <= code_nxt;
    zq_r   <= zq_nxt;
    kx_r   <= kx_nxt;
    bi_r   <= bi_nxt;
    sym_r  <= sym_nxt;
    j_r    <= j_nxt;
    d_r    <= d_nxt;
    cand_r <= cand_nxt;
    f_r    <= f_nxt;
  end

endmodule
